[sv/mse_pkg.sv]
// mse_pkg: shared constants, instruction codes and structs of the mips subset execute block
// no dependencies; used by every module and interface of the block
package mse_pkg;

  localparam int MEM_WORDS = 8192;
  localparam int DM_AW     = $clog2(MEM_WORDS);
  localparam int PC_BITS   = 16;
  localparam int OUT_PC_W  = 16;
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = $clog2(RF_DEPTH);
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = OQ_AW + 1;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_JAL   = 6'b000011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_BNE   = 6'b000101;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;

  // funct codes of opcode zero
  localparam logic [5:0] FN_JR  = 6'b001000;
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;

  localparam logic [RF_AW-1:0] LINK_REG = RF_AW'(31);

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] idx;
    logic [31:0]      val;
  } rf_wr_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [DM_AW-1:0] addr;
    logic [31:0]      wdata;
  } dm_req_t;

  typedef struct packed {
    logic [OUT_PC_W-1:0] next_pc;
    logic                illegal;
    logic                reg_written;
    logic [RF_AW-1:0]    write_index;
    logic [31:0]         write_value;
  } result_t;

endpackage

[sv/mse_if.sv]
// mse_in_if / mse_out_if: valid-ready channels for instruction words and result words
// depends on mse_pkg for field widths
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mse_out_if;
  logic                         valid;
  logic                         ready;
  logic [mse_pkg::OUT_PC_W-1:0] next_pc;
  logic                         illegal;
  logic                         reg_written;
  logic [mse_pkg::RF_AW-1:0]    write_index;
  logic [31:0]                  write_value;

  modport source (output valid, output next_pc, output illegal, output reg_written,
                  output write_index, output write_value, input ready);
  modport sink (input valid, input next_pc, input illegal, input reg_written,
                input write_index, input write_value, output ready);
endinterface

[sv/mips_subset_execute.sv]
// Executes one MIPS instruction word per accepted input word (add, sub, and, or, slt, jr,
// addi, beq, bne, lw, sw, j, jal) and returns one result word each, in order. After reset
// the data memory is swept to zero, one word a cycle, and in_ch.ready stays low until the
// sweep ends. ALU, branch, jump and store instructions are accepted back to back while the
// output queue has room; after a load, the following instruction waits in execute while
// the load's data memory read returns and the load writes back. Each result word passes
// the execute register (and the load register for a load) and is registered in the output
// queue before it is valid; up to four results queue at the output.
// depends on mse_pkg, mse_if, mse_regfile, mse_dmem, mse_outq
module mips_subset_execute (
  input  logic      clk,
  input  logic      rst_n,
  mse_in_if.sink    in_ch,
  mse_out_if.source out_ch
);
  import mse_pkg::*;

  logic                accept;
  logic                pop;
  logic [OQ_CNT_W-1:0] oq_cnt;
  logic [OQ_CNT_W-1:0] inflight;
  logic                dm_busy;
  logic [31:0]         dm_rdata;
  dm_req_t             dm_req;
  rf_wr_t              rf_wr;
  logic [31:0]         rf_a;
  logic [31:0]         rf_b;
  logic                oq_push;
  result_t             oq_item;
  result_t             oq_head;

  logic                e_vld_r, e_vld_nxt;
  logic [31:0]         e_ins_r, e_ins_nxt;
  logic                m_vld_r, m_vld_nxt;
  logic [RF_AW-1:0]    m_widx_r, m_widx_nxt;
  logic [PC_BITS-1:0]  m_npc_r, m_npc_nxt;
  logic [PC_BITS-1:0]  pc_r, pc_nxt;
  logic                ovr_a_vld_r, ovr_a_vld_nxt;
  logic [31:0]         ovr_a_r, ovr_a_nxt;
  logic                ovr_b_vld_r, ovr_b_vld_nxt;
  logic [31:0]         ovr_b_r, ovr_b_nxt;

  logic                e_go;
  logic [5:0]          op;
  logic [5:0]          fn;
  logic [RF_AW-1:0]    rs;
  logic [RF_AW-1:0]    rt;
  logic [RF_AW-1:0]    rd;
  logic [RF_AW-1:0]    in_rs;
  logic [RF_AW-1:0]    in_rt;
  logic [31:0]         imm_sx;
  logic [31:0]         op_a;
  logic [31:0]         op_b;
  logic [31:0]         addr32;
  logic [PC_BITS-1:0]  inc;
  logic [31:0]         inc32;
  logic [31:0]         jmp32;
  logic [31:0]         br32;
  logic [PC_BITS-1:0]  ex_npc;
  logic                ex_bad;
  logic                ex_wr;
  logic [RF_AW-1:0]    ex_widx;
  logic [31:0]         ex_wval;
  logic                ex_load;
  logic                ex_store;
  logic                m_wr;

  mse_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept),
    .ra_a  (in_rs),
    .ra_b  (in_rt),
    .wr    (rf_wr),
    .rd_a  (rf_a),
    .rd_b  (rf_b)
  );

  mse_dmem u_dm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dm_req),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  mse_outq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_item),
    .pop       (pop),
    .head      (oq_head),
    .cnt       (oq_cnt)
  );

  // every word in execute, load or queue holds a queue slot
  assign inflight     = OQ_CNT_W'(e_vld_r) + OQ_CNT_W'(m_vld_r) + oq_cnt;
  assign in_ch.ready  = !dm_busy && (inflight < OQ_CNT_W'(OQ_DEPTH)) && !(e_vld_r && m_vld_r);
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_rs        = in_ch.instruction[25:21];
  assign in_rt        = in_ch.instruction[20:16];

  assign out_ch.valid       = oq_cnt != '0;
  assign out_ch.next_pc     = oq_head.next_pc;
  assign out_ch.illegal     = oq_head.illegal;
  assign out_ch.reg_written = oq_head.reg_written;
  assign out_ch.write_index = oq_head.write_index;
  assign out_ch.write_value = oq_head.write_value;
  assign pop                = out_ch.valid && out_ch.ready;

  // execute stage decode and datapath
  always_comb begin
    op     = e_ins_r[31:26];
    fn     = e_ins_r[5:0];
    rs     = e_ins_r[25:21];
    rt     = e_ins_r[20:16];
    rd     = e_ins_r[15:11];
    imm_sx = {{16{e_ins_r[15]}}, e_ins_r[15:0]};
    op_a   = ovr_a_vld_r ? ovr_a_r : rf_a;
    op_b   = ovr_b_vld_r ? ovr_b_r : rf_b;
    addr32 = op_a + imm_sx;
    inc    = pc_r + PC_BITS'(1);
    inc32  = 32'(inc);
    jmp32  = {inc32[31:26], e_ins_r[25:0]};
    br32   = inc32 + imm_sx;

    ex_npc   = inc;
    ex_bad   = 1'b0;
    ex_wr    = 1'b0;
    ex_widx  = '0;
    ex_wval  = '0;
    ex_load  = 1'b0;
    ex_store = 1'b0;

    case (op)
      OP_RTYPE: begin
        ex_wr   = 1'b1;
        ex_widx = rd;
        case (fn)
          FN_ADD: ex_wval = op_a + op_b;
          FN_SUB: ex_wval = op_a - op_b;
          FN_AND: ex_wval = op_a & op_b;
          FN_OR:  ex_wval = op_a | op_b;
          FN_SLT: ex_wval = 32'($signed(op_a) < $signed(op_b));
          FN_JR: begin
            ex_wr  = 1'b0;
            ex_npc = op_a[PC_BITS-1:0];
          end
          default: begin
            ex_wr  = 1'b0;
            ex_bad = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        ex_wr   = 1'b1;
        ex_widx = rt;
        ex_wval = addr32;
      end
      OP_BEQ: begin
        if (op_a == op_b) begin
          ex_npc = br32[PC_BITS-1:0];
        end
      end
      OP_BNE: begin
        if (op_a != op_b) begin
          ex_npc = br32[PC_BITS-1:0];
        end
      end
      OP_LW: begin
        ex_load = 1'b1;
      end
      OP_SW: begin
        ex_store = 1'b1;
      end
      OP_J: begin
        ex_npc = jmp32[PC_BITS-1:0];
      end
      OP_JAL: begin
        ex_wr   = 1'b1;
        ex_widx = LINK_REG;
        ex_wval = inc32;
        ex_npc  = jmp32[PC_BITS-1:0];
      end
      default: begin
        ex_bad = 1'b1;
      end
    endcase

    if (ex_bad) begin
      ex_npc = pc_r;
      ex_wr  = 1'b0;
    end
    // register zero swallows writes
    if (!ex_wr || ex_widx == '0) begin
      ex_wr   = 1'b0;
      ex_widx = '0;
      ex_wval = '0;
    end
  end

  // execute retires unless a load is still writing back
  assign e_go = e_vld_r && !m_vld_r;
  assign m_wr = m_widx_r != '0;

  always_comb begin
    dm_req.re    = e_go && ex_load;
    dm_req.we    = e_go && ex_store;
    dm_req.addr  = addr32[DM_AW-1:0];
    dm_req.wdata = op_b;

    rf_wr   = '0;
    oq_push = 1'b0;
    oq_item = '0;
    if (m_vld_r) begin
      rf_wr.en            = m_wr;
      rf_wr.idx           = m_widx_r;
      rf_wr.val           = dm_rdata;
      oq_push             = 1'b1;
      oq_item.next_pc     = OUT_PC_W'(m_npc_r);
      oq_item.reg_written = m_wr;
      oq_item.write_index = m_widx_r;
      oq_item.write_value = m_wr ? dm_rdata : '0;
    end else if (e_go && !ex_load) begin
      rf_wr.en            = ex_wr;
      rf_wr.idx           = ex_widx;
      rf_wr.val           = ex_wval;
      oq_push             = 1'b1;
      oq_item.next_pc     = OUT_PC_W'(ex_npc);
      oq_item.illegal     = ex_bad;
      oq_item.reg_written = ex_wr;
      oq_item.write_index = ex_widx;
      oq_item.write_value = ex_wval;
    end
  end

  always_comb begin
    e_vld_nxt  = e_vld_r;
    e_ins_nxt  = e_ins_r;
    m_vld_nxt  = m_vld_r;
    m_widx_nxt = m_widx_r;
    m_npc_nxt  = m_npc_r;
    pc_nxt     = pc_r;

    if (m_vld_r) begin
      m_vld_nxt = 1'b0;
    end
    if (e_go) begin
      e_vld_nxt = 1'b0;
      pc_nxt    = ex_npc;
      if (ex_load) begin
        m_vld_nxt  = 1'b1;
        m_widx_nxt = rt;
        m_npc_nxt  = ex_npc;
      end
    end
    if (accept) begin
      e_vld_nxt = 1'b1;
      e_ins_nxt = in_ch.instruction;
    end

    // a write landing at or after the operand read is patched in here
    ovr_a_vld_nxt = ovr_a_vld_r;
    ovr_a_nxt     = ovr_a_r;
    ovr_b_vld_nxt = ovr_b_vld_r;
    ovr_b_nxt     = ovr_b_r;
    if (accept) begin
      ovr_a_vld_nxt = rf_wr.en && rf_wr.idx == in_rs;
      ovr_a_nxt     = rf_wr.val;
      ovr_b_vld_nxt = rf_wr.en && rf_wr.idx == in_rt;
      ovr_b_nxt     = rf_wr.val;
    end else begin
      if (rf_wr.en && rf_wr.idx == rs) begin
        ovr_a_vld_nxt = 1'b1;
        ovr_a_nxt     = rf_wr.val;
      end
      if (rf_wr.en && rf_wr.idx == rt) begin
        ovr_b_vld_nxt = 1'b1;
        ovr_b_nxt     = rf_wr.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      pc_r        <= '0;
      ovr_a_vld_r <= 1'b0;
      ovr_b_vld_r <= 1'b0;
    end else begin
      e_vld_r     <= e_vld_nxt;
      m_vld_r     <= m_vld_nxt;
      pc_r        <= pc_nxt;
      ovr_a_vld_r <= ovr_a_vld_nxt;
      ovr_b_vld_r <= ovr_b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_ins_r  <= e_ins_nxt;
    m_widx_r <= m_widx_nxt;
    m_npc_r  <= m_npc_nxt;
    ovr_a_r  <= ovr_a_nxt;
    ovr_b_r  <= ovr_b_nxt;
  end

endmodule

[sv/mse_regfile.sv]
// mse_regfile: 32 x 32 register file, two registered read ports, one write port
// entries read as zero until first written; depends on mse_pkg
module mse_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      re,
  input  logic [mse_pkg::RF_AW-1:0] ra_a,
  input  logic [mse_pkg::RF_AW-1:0] ra_b,
  input  mse_pkg::rf_wr_t           wr,
  output logic [31:0]               rd_a,
  output logic [31:0]               rd_b
);
  import mse_pkg::*;

  logic [31:0]         rf_mem_r [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld_r;
  logic [RF_DEPTH-1:0] vld_nxt;
  logic [31:0]         qa_r;
  logic [31:0]         qb_r;
  logic                qa_vld_r;
  logic                qb_vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rf_mem_r[wr.idx] <= wr.val;
    end
    if (re) begin
      qa_r     <= rf_mem_r[ra_a];
      qb_r     <= rf_mem_r[ra_b];
      qa_vld_r <= vld_r[ra_a];
      qb_vld_r <= vld_r[ra_b];
    end
  end

  assign rd_a = qa_vld_r ? qa_r : '0;
  assign rd_b = qb_vld_r ? qb_r : '0;

endmodule

[sv/mse_dmem.sv]
// mse_dmem: word-addressed data memory with one registered read and one write a cycle
// sweeps every word to zero after reset; depends on mse_pkg
module mse_dmem (
  input  logic             clk,
  input  logic             rst_n,
  input  mse_pkg::dm_req_t req,
  output logic [31:0]      rdata,
  output logic             busy
);
  import mse_pkg::*;

  logic [31:0]      dm_mem_r [MEM_WORDS];
  logic [31:0]      rdata_r;
  logic             clr_r;
  logic             clr_nxt;
  logic [DM_AW-1:0] clr_addr_r;
  logic [DM_AW-1:0] clr_addr_nxt;
  logic             wen;
  logic [DM_AW-1:0] waddr;
  logic [31:0]      wdata;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + DM_AW'(1);
      if (clr_addr_r == DM_AW'(MEM_WORDS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign wen   = clr_r || req.we;
  assign waddr = clr_r ? clr_addr_r : req.addr;
  assign wdata = clr_r ? '0 : req.wdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      dm_mem_r[waddr] <= wdata;
    end
    if (req.re) begin
      rdata_r <= dm_mem_r[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule

[sv/mse_outq.sv]
// mse_outq: small result queue between the execute logic and the result channel
// depends on mse_pkg for the result struct and depth
module mse_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  mse_pkg::result_t             push_item,
  input  logic                         pop,
  output mse_pkg::result_t             head,
  output logic [mse_pkg::OQ_CNT_W-1:0] cnt
);
  import mse_pkg::*;

  result_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0]    wp_r;
  logic [OQ_AW-1:0]    wp_nxt;
  logic [OQ_AW-1:0]    rp_r;
  logic [OQ_AW-1:0]    rp_nxt;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + OQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

  assign head = q_r[rp_r];
  assign cnt  = cnt_r;

endmodule

[sv/mse_checker.sv]
// mse_checker: port-level checks of the mips subset execute block, bound to its top level
// depends on mse_pkg for widths
module mse_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mse_pkg::OUT_PC_W-1:0] out_next_pc,
  input logic                         out_illegal,
  input logic                         out_reg_written,
  input logic [mse_pkg::RF_AW-1:0]    out_write_index,
  input logic [31:0]                  out_write_value
);
  import mse_pkg::*;

  // memory sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_illegal)
      && $stable(out_reg_written) && $stable(out_write_index) && $stable(out_write_value))
    else $error("stalled result word changed");

  a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> !out_reg_written)
    else $error("illegal instruction wrote a register");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_written |-> out_write_index == '0 && out_write_value == '0)
    else $error("write fields not zero without a write");

  a_write_not_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_written |-> out_write_index != '0)
    else $error("write reported to register zero");

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_next_pc     (out_ch.next_pc),
  .out_illegal     (out_ch.illegal),
  .out_reg_written (out_ch.reg_written),
  .out_write_index (out_ch.write_index),
  .out_write_value (out_ch.write_value)
);
